// ===== rtl/slss_pkg.sv =====
package slss_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = 6;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int VAL_W = 32;
	localparam int CNT_OUT_W = 7;
	localparam int GRP = 8;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]              op;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] result_value;
		logic [POS_W-1:0]        result_position;
		logic                    position_valid;
		logic [CNT_OUT_W-1:0]    entry_count;
	} result_t;

	// per-cell compare results, captured at the item transfer
	typedef struct packed {
		logic valid;   // cell holds a live entry
		logic stop;    // live entry that does not go before the new value
		logic eq;      // live entry equal to the key
		logic sel;     // cell index equals the requested position
		logic ge_pos;  // cell index at or above the requested position
	} cell_flag_t;

	typedef struct packed {
		logic load_new;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

endpackage

// ===== rtl/slss_cell.sv =====
module slss_cell import slss_pkg::*; (
	input  logic                    clk,
	input  logic [IDX_W-1:0]        index,
	input  logic                    capture,
	input  logic signed [VAL_W-1:0] key,
	input  logic [POS_W-1:0]        position,
	input  logic                    desc,
	input  logic [CNT_W-1:0]        count,
	input  cell_ctl_t               ctl,
	input  logic signed [VAL_W-1:0] left_value,
	input  logic signed [VAL_W-1:0] right_value,
	output logic signed [VAL_W-1:0] value,
	output cell_flag_t              flags
);

	logic signed [VAL_W-1:0] value_q;
	cell_flag_t flags_q;
	cell_flag_t flags_d;
	logic goes_before;

	always_comb begin
		goes_before = desc ? (value_q >= key) : (value_q <= key);
		flags_d.valid = CNT_W'(index) < count;
		flags_d.stop = flags_d.valid && !goes_before;
		flags_d.eq = flags_d.valid && (value_q == key);
		flags_d.sel = CMP_W'(index) == CMP_W'(position);
		flags_d.ge_pos = CMP_W'(index) >= CMP_W'(position);
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			flags_q <= flags_d;
		end
		if (ctl.load_new) begin
			value_q <= key;
		end else if (ctl.take_left) begin
			value_q <= left_value;
		end else if (ctl.take_right) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;
	assign flags = flags_q;

endmodule

// ===== rtl/slss_resolve.sv =====
module slss_resolve import slss_pkg::*; (
	input  logic [CAPACITY-1:0] valid_v,
	input  logic [CAPACITY-1:0] stop_v,
	input  logic [CAPACITY-1:0] eq_v,
	input  logic [CAPACITY-1:0] ge_pos_v,
	input  logic                do_ins,
	input  logic                do_rem,
	output cell_ctl_t           ctl [CAPACITY],
	output logic [CAPACITY-1:0] first_eq
);

	localparam logic [CAPACITY-1:0] ONE = {{(CAPACITY-1){1'b0}}, 1'b1};

	logic [CAPACITY-1:0] mark;
	logic [CAPACITY-1:0] mark_neg;
	logic [CAPACITY-1:0] at_v;
	logic [CAPACITY-1:0] ge_v;

	always_comb begin
		// first stop cell, or the first free cell when every entry goes before
		mark = stop_v | (~valid_v & {valid_v[CAPACITY-2:0], 1'b1});
		mark_neg = ~mark + ONE;
		at_v = mark & mark_neg;
		ge_v = mark | mark_neg;
		first_eq = eq_v & (~eq_v + ONE);
		for (int i = 0; i < CAPACITY; i++) begin
			ctl[i].load_new = do_ins && at_v[i];
			ctl[i].take_left = do_ins && ge_v[i] && !at_v[i] && (i > 0);
			ctl[i].take_right = do_rem && ge_pos_v[i] && (i < CAPACITY - 1);
		end
	end

endmodule

// ===== rtl/sorted_list_store_core.sv =====
// Items are not overlapped: the cell compare, the first-match resolve with the
// cell shift, and the final reduction of the read value run in turn, and the
// input stalls until the sequencer is back in its idle state.
// A result waiting on a stalled output holds the sequencer in its final step,
// and the input stalls until that result transfers.
// Reset (arst_n low, asynchronous) clears the entry count, the order bit and
// the sequencer; cell contents are not reset and are never read before written.
module sorted_list_store_core import slss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_data
);

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_REDUCE,
		SEQ_RESULT
	} state_t;

	state_t state_q;
	result_t result_q;
	logic result_valid_q;
	logic desc_q;
	logic [CNT_W-1:0] count_q;
	item_t item_q;
	logic [1:0] status_q;
	logic [CAPACITY-1:0] hit_q;
	logic signed [VAL_W-1:0] grp_q [NGRP];

	logic take;
	logic load_result;
	logic signed [VAL_W-1:0] cell_val [CAPACITY];
	cell_flag_t cell_flags [CAPACITY];
	cell_ctl_t cell_ctl [CAPACITY];
	logic [CAPACITY-1:0] valid_v, stop_v, eq_v, sel_v, ge_pos_v, first_eq;
	logic full, pos_ok, in_reduce, do_ins, do_rem;
	logic [1:0] status_d;
	logic signed [VAL_W-1:0] grp_d [NGRP];
	logic signed [VAL_W-1:0] read_val;
	logic [IDX_W-1:0] hit_idx;
	result_t result_d;

	assign item_stall = state_q != SEQ_IDLE;
	assign take = item_valid && !item_stall;
	assign cfg_ready = 1'b1;
	assign load_result = (state_q == SEQ_RESULT) && (!result_valid_q || !result_stall);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		slss_cell u_cell (
			.clk(clk),
			.index(IDX_W'(i)),
			.capture(take),
			.key(take ? item.value : item_q.value),
			.position(item.position),
			.desc(desc_q),
			.count(count_q),
			.ctl(cell_ctl[i]),
			.left_value((i == 0) ? cell_val[i] : cell_val[(i == 0) ? 0 : i - 1]),
			.right_value(cell_val[(i == CAPACITY - 1) ? i : i + 1]),
			.value(cell_val[i]),
			.flags(cell_flags[i])
		);
		assign valid_v[i] = cell_flags[i].valid;
		assign stop_v[i] = cell_flags[i].stop;
		assign eq_v[i] = cell_flags[i].eq;
		assign sel_v[i] = cell_flags[i].sel;
		assign ge_pos_v[i] = cell_flags[i].ge_pos;
	end

	slss_resolve u_resolve (
		.valid_v(valid_v),
		.stop_v(stop_v),
		.eq_v(eq_v),
		.ge_pos_v(ge_pos_v),
		.do_ins(do_ins),
		.do_rem(do_rem),
		.ctl(cell_ctl),
		.first_eq(first_eq)
	);

	always_comb begin
		in_reduce = state_q == SEQ_REDUCE;
		full = count_q == CNT_W'(CAPACITY);
		pos_ok = CMP_W'(item_q.position) < CMP_W'(count_q);
		do_ins = in_reduce && (item_q.op == OP_INSERT) && !full;
		do_rem = in_reduce && (item_q.op == OP_REMOVE) && pos_ok;
		case (item_q.op)
			OP_INSERT: status_d = full ? ST_FULL : ST_OK;
			OP_FIND:   status_d = (|first_eq) ? ST_OK : ST_NOTFOUND;
			OP_REMOVE,
			OP_READ:   status_d = pos_ok ? ST_OK : ST_BADPOS;
			default:   status_d = ST_OK;
		endcase
		// first level of the read-value OR tree, pre-shift contents
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < CAPACITY) begin
					grp_d[g] = grp_d[g] | (cell_val[g * GRP + k] & {VAL_W{sel_v[g * GRP + k]}});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item;
		end
		if (in_reduce) begin
			status_q <= status_d;
			hit_q <= (item_q.op == OP_FIND) ? first_eq : sel_v;
			for (int g = 0; g < NGRP; g++) begin
				grp_q[g] <= grp_d[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			desc_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				desc_q <= cfg_data;
			end
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		read_val = '0;
		for (int g = 0; g < NGRP; g++) begin
			read_val = read_val | grp_q[g];
		end
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_q[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
		result_d.status = status_q;
		result_d.entry_count = CNT_OUT_W'(count_q);
		result_d.result_value = '0;
		result_d.result_position = '0;
		result_d.position_valid = 1'b0;
		if (status_q == ST_OK) begin
			case (item_q.op)
				OP_REMOVE: begin
					result_d.result_value = read_val;
					// count already reflects the removal here
					if (CMP_W'(item_q.position) < CMP_W'(count_q)) begin
						result_d.result_position = item_q.position;
						result_d.position_valid = 1'b1;
					end
				end
				OP_FIND: begin
					result_d.result_position = POS_W'(hit_idx);
					result_d.position_valid = 1'b1;
				end
				OP_READ: begin
					result_d.result_value = read_val;
					result_d.result_position = item_q.position;
					result_d.position_valid = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			result_valid_q <= 1'b0;
			result_q <= '0;
		end else begin
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				SEQ_IDLE: begin
					if (take) begin
						state_q <= SEQ_REDUCE;
					end
				end
				SEQ_REDUCE: begin
					state_q <= SEQ_RESULT;
				end
				SEQ_RESULT: begin
					if (load_result) begin
						result_q <= result_d;
						state_q <= SEQ_IDLE;
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not advance the entry count");
	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_rem |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not retire an entry");
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_RESULT) |-> $onehot0(hit_q))
		else $error("more than one cell matched");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");
	a_no_full_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.status != ST_OK) |-> !result_q.position_valid)
		else $error("failed operation reports a position");
`endif

endmodule

// ===== bench/tb_sorted_list_store_core.sv =====
`timescale 1ns / 100ps

module tb_sorted_list_store_core;
	import slss_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 250;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
	localparam logic signed [VAL_W-1:0] VAL_NEG_ONE = -32'sd1;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic    cfg_data;

	// shadow copy of the list, updated at each item transfer
	logic signed [VAL_W-1:0] shadow_cells [CAPACITY];
	int      shadow_count = 0;
	bit      shadow_descending = 0;
	result_t pending_results [$];

	int errors = 0;
	bit gaps_on = 1;
	int hold_request = 0;
	int quiet_cycles = 0;

	sorted_list_store_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= 50) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	function automatic bit goes_first(logic signed [VAL_W-1:0] stored,
			logic signed [VAL_W-1:0] incoming);
		return shadow_descending ? (stored >= incoming) : (stored <= incoming);
	endfunction

	function automatic result_t apply_list_op(item_t it);
		result_t r;
		int      at;
		int      i;
		r = '0;
		r.status = ST_OK;
		case (it.op)
			OP_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					at = 0;
					while (at < shadow_count && goes_first(shadow_cells[at], it.value))
						at++;
					for (i = shadow_count; i > at; i--)
						shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[at] = it.value;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				if (int'(it.position) >= shadow_count) begin
					r.status = ST_BADPOS;
				end else begin
					r.result_value = shadow_cells[it.position];
					for (i = it.position; i + 1 < shadow_count; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_count--;
					// entry that slid into the hole, if any
					if (int'(it.position) < shadow_count) begin
						r.result_position = it.position;
						r.position_valid = 1'b1;
					end
				end
			end
			OP_FIND: begin
				r.status = ST_NOTFOUND;
				for (i = 0; i < shadow_count; i++) begin
					if (!r.position_valid && shadow_cells[i] == it.value) begin
						r.status = ST_OK;
						r.result_position = POS_W'(i);
						r.position_valid = 1'b1;
					end
				end
			end
			default: begin
				if (int'(it.position) >= shadow_count) begin
					r.status = ST_BADPOS;
				end else begin
					r.result_value = shadow_cells[it.position];
					r.result_position = it.position;
					r.position_valid = 1'b1;
				end
			end
		endcase
		r.entry_count = CNT_OUT_W'(shadow_count);
		return r;
	endfunction

	task automatic check_result(result_t got, result_t want);
		if (got.status !== want.status)
			report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
		if (got.result_value !== want.result_value)
			report_mismatch($sformatf("result_value got %0d want %0d",
				got.result_value, want.result_value));
		if (got.result_position !== want.result_position)
			report_mismatch($sformatf("result_position got %0d want %0d",
				got.result_position, want.result_position));
		if (got.position_valid !== want.position_valid)
			report_mismatch($sformatf("position_valid got %0b want %0b",
				got.position_valid, want.position_valid));
		if (got.entry_count !== want.entry_count)
			report_mismatch($sformatf("entry_count got %0d want %0d",
				got.entry_count, want.entry_count));
	endtask

	// result side: random stalls, plus a counted hold-off on request
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				result_stall = 1'b1;
				hold_request--;
			end else if (gaps_on) begin
				result_stall = ($urandom_range(99) < 36);
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	initial begin
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = pending_results.pop_front();
					check_result(result, want);
				end
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("sorted_list_store_core regression: fail");
		$finish;
	end

	// called and returns at a falling edge; valid stays high for back-to-back items
	task automatic send_op(logic [1:0] op, logic signed [VAL_W-1:0] value,
			logic [POS_W-1:0] pos);
		item_t it;
		it.op = op;
		it.value = value;
		it.position = pos;
		if (gaps_on && $urandom_range(99) < 36) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(apply_list_op(it));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		item_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_order(bit descending);
		wait_idle();
		cfg_data = descending;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		shadow_descending = descending;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return int'($urandom_range(0, 32)) - 16;
		if (r < 50) begin
			case ($urandom_range(3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return '0;
				default: return VAL_NEG_ONE;
			endcase
		end
		return $urandom;
	endfunction

	task automatic test_empty_store();
		write_order(1'b0);
		send_op(OP_READ, '0, 0);
		send_op(OP_REMOVE, '0, 0);
		send_op(OP_FIND, '0, 0);
		send_op(OP_READ, VAL_NEG_ONE, 63);
	endtask

	task automatic test_ascending_ops();
		send_op(OP_INSERT, VAL_MAX, 0);
		send_op(OP_INSERT, VAL_MIN, 63);
		send_op(OP_INSERT, '0, 0);
		send_op(OP_INSERT, VAL_NEG_ONE, 0);
		send_op(OP_INSERT, VAL_NEG_ONE, 0);
		send_op(OP_INSERT, 5, 0);
		send_op(OP_FIND, VAL_NEG_ONE, 0);    // first of the two equal entries
		send_op(OP_FIND, 42, 0);
		send_op(OP_READ, '0, 0);
		send_op(OP_READ, '0, 5);
		send_op(OP_READ, '0, 6);
		send_op(OP_REMOVE, '0, 2);
		send_op(OP_REMOVE, '0, 4);           // last entry: nothing follows
		send_op(OP_REMOVE, '0, 0);
		send_op(OP_REMOVE, '0, 63);
	endtask

	task automatic test_descending_order();
		write_order(1'b1);
		send_op(OP_INSERT, 9, 0);
		send_op(OP_INSERT, VAL_MIN, 0);
		send_op(OP_INSERT, VAL_MAX, 0);
		send_op(OP_INSERT, 9, 0);
		send_op(OP_READ, '0, 0);
		send_op(OP_FIND, 9, 0);
		while (shadow_count > 0) send_op(OP_REMOVE, '0, 0);
	endtask

	// receiver holds off while the sender streams inserts, then the store fills up
	task automatic test_full_store_backpressure();
		write_order(1'b0);
		gaps_on = 0;
		hold_request = HOLD_CYCLES;
		while (shadow_count < CAPACITY)
			send_op(OP_INSERT, int'($urandom_range(0, 15)) - 8, POS_W'($urandom_range(63)));
		send_op(OP_INSERT, VAL_MAX, 0);
		send_op(OP_INSERT, VAL_MIN, 0);
		send_op(OP_READ, '0, 63);
		send_op(OP_REMOVE, '0, 63);
		send_op(OP_INSERT, VAL_MAX, 0);
		send_op(OP_READ, '0, 63);
		send_op(OP_FIND, VAL_MAX, 0);
		wait_idle();
		gaps_on = 1;
	endtask

	task automatic random_op(int target);
		int                      r;
		logic [1:0]              op;
		logic signed [VAL_W-1:0] v;
		logic [POS_W-1:0]        p;
		r = $urandom_range(99);
		if (shadow_count < target)
			op = (r < 55) ? OP_INSERT : (r < 70) ? OP_REMOVE : (r < 85) ? OP_FIND : OP_READ;
		else
			op = (r < 20) ? OP_INSERT : (r < 60) ? OP_REMOVE : (r < 80) ? OP_FIND : OP_READ;
		v = pick_value();
		if (op == OP_FIND && shadow_count > 0 && $urandom_range(99) < 60)
			v = shadow_cells[IDX_W'($urandom_range(0, shadow_count - 1))];
		if (shadow_count > 0 && $urandom_range(99) < 75)
			p = POS_W'($urandom_range(0, shadow_count - 1));
		else
			p = POS_W'($urandom_range(63));
		send_op(op, v, p);
	endtask

	task automatic test_random_mix();
		int targets [4] = '{8, 64, 40, 64};
		for (int ph = 0; ph < 4; ph++) begin
			write_order(ph[0]);
			gaps_on = (ph != 2);
			repeat (PHASE_ITEMS) random_op(targets[ph]);
		end
		gaps_on = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_store();
		test_ascending_ops();
		test_descending_order();
		test_full_store_backpressure();
		test_random_mix();

		wait_idle();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (errors == 0)
			$display("sorted_list_store_core regression: pass");
		else
			$display("sorted_list_store_core regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/slss_pkg.sv
rtl/slss_cell.sv
rtl/slss_resolve.sv
rtl/sorted_list_store_core.sv
bench/tb_sorted_list_store_core.sv
